// File: design/avc_config_record_parser_top_assert.svh
// Assertion macros shared by the configuration record parser modules.
`ifndef AVC_CONFIG_RECORD_PARSER_TOP_ASSERT_SVH
`define AVC_CONFIG_RECORD_PARSER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define AVCP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define AVCP_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define AVCP_ASSERT(label, prop, msg)
`define AVCP_NEVER(label, cond, msg)
`endif
`endif

// File: design/avcp_pkg.sv
// Types and constants of the configuration record parser.
`timescale 1ns / 1ps
package avcp_pkg;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_VERSION,
		PH_PROFILE,
		PH_COMPAT,
		PH_LEVEL,
		PH_LENSIZE,
		PH_SPSCOUNT,
		PH_LEN_HI,
		PH_LEN_LO,
		PH_PAYLOAD,
		PH_PPSCOUNT,
		PH_CHROMA,
		PH_LUMA,
		PH_CHROMAD,
		PH_EXTCOUNT,
		PH_TRAILING
	} phase_t;

	typedef enum logic [1:0] {
		LIST_SPS,
		LIST_PPS,
		LIST_EXT
	} list_t;

	localparam logic [4:0] KIND_VERSION     = 5'd0;
	localparam logic [4:0] KIND_PROFILE     = 5'd1;
	localparam logic [4:0] KIND_COMPAT      = 5'd2;
	localparam logic [4:0] KIND_LEVEL       = 5'd3;
	localparam logic [4:0] KIND_LENSIZE     = 5'd4;
	localparam logic [4:0] KIND_SPSCOUNT    = 5'd5;
	localparam logic [4:0] KIND_SPSLEN      = 5'd6;
	localparam logic [4:0] KIND_SPSBYTE     = 5'd7;
	localparam logic [4:0] KIND_PPSCOUNT    = 5'd8;
	localparam logic [4:0] KIND_PPSLEN      = 5'd9;
	localparam logic [4:0] KIND_PPSBYTE     = 5'd10;
	localparam logic [4:0] KIND_CHROMA      = 5'd11;
	localparam logic [4:0] KIND_LUMADEPTH   = 5'd12;
	localparam logic [4:0] KIND_CHROMADEPTH = 5'd13;
	localparam logic [4:0] KIND_EXTCOUNT    = 5'd14;
	localparam logic [4:0] KIND_EXTLEN      = 5'd15;
	localparam logic [4:0] KIND_EXTBYTE     = 5'd16;
	localparam logic [4:0] KIND_TRAILING    = 5'd17;

	localparam logic [7:0] MASK_LENSIZE  = 8'h03;
	localparam logic [7:0] MASK_CHROMA   = 8'h03;
	localparam logic [7:0] MASK_SPSCOUNT = 8'h1F;
	localparam logic [7:0] MASK_DEPTH    = 8'h07;

	localparam logic [7:0] PROFILE_HIGH     = 8'd100;
	localparam logic [7:0] PROFILE_HIGH10   = 8'd110;
	localparam logic [7:0] PROFILE_HIGH422  = 8'd122;
	localparam logic [7:0] PROFILE_HIGH444  = 8'd144;
	localparam int         EXT_MIN_BYTES    = 4;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

	// One tagged result word.
	typedef struct packed {
		logic        truncated;
		logic        ext_present;
		logic        record_last;
		logic [15:0] byte_index;
		logic [7:0]  set_index;
		logic [15:0] field_value;
		logic [4:0]  field_kind;
	} res_t;

	function automatic logic is_high_profile(logic [7:0] p);
		return p == PROFILE_HIGH || p == PROFILE_HIGH10 ||
			p == PROFILE_HIGH422 || p == PROFILE_HIGH444;
	endfunction

endpackage

// File: design/avc_config_record_parser_top.sv
// Top level of the AVC decoder configuration record parser.
`timescale 1ns / 1ps
// Tags each byte of an avcC record with its field (header bytes, parameter
// set counts, lengths and payload bytes, high-profile extension, trailing).
// One word in and one tagged word out per cycle while neither the full queue
// nor the output holds them back: the classifier updates its field state as
// each byte is taken, and a four-entry queue plus an output register keep
// input and output stalls apart. Bytes that arrive while idle (no first_byte
// since the last record ended) produce no output word.
module avc_config_record_parser_top #(
	parameter int RECORD_LENGTH_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // data_byte[7:0], record_length[23:8]
	input  logic        s_axis_tuser,  // first_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// field_value[15:0], set_index[23:16], byte_index[39:24],
	// ext_present[40], truncated[41], zero[47:42]
	output logic [47:0] m_axis_tdata,
	output logic [4:0]  m_axis_tuser,  // field_kind
	output logic        m_axis_tlast   // record_last
);

	avcp_pkg::res_t f_res, q_data, o_data;
	logic           push, pop, q_full, q_empty;

	avcp_front #(
		.RECORD_LENGTH_BITS(RECORD_LENGTH_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.data_byte    (s_axis_tdata[7:0]),
		.first_byte   (s_axis_tuser),
		.record_length(s_axis_tdata[23:8]),
		.q_full       (q_full),
		.push         (push),
		.res          (f_res)
	);

	avcp_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (f_res),
		.pop   (pop),
		.rdata (q_data),
		.full  (q_full),
		.empty (q_empty)
	);

	avcp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_data   (q_data),
		.pop      (pop),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data (o_data)
	);

	assign m_axis_tdata = {6'd0, o_data.truncated, o_data.ext_present, o_data.byte_index,
		o_data.set_index, o_data.field_value};
	assign m_axis_tuser = o_data.field_kind;
	assign m_axis_tlast = o_data.record_last;

endmodule

// File: design/avcp_front.sv
// Byte classifier: runs the record field walk and tags each accepted byte.
`timescale 1ns / 1ps
`include "avc_config_record_parser_top_assert.svh"
module avcp_front #(
	parameter int RECORD_LENGTH_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         data_byte,
	input  logic               first_byte,
	input  logic [15:0]        record_length,
	input  logic               q_full,
	output logic               push,
	output avcp_pkg::res_t     res
);

	localparam int LW = RECORD_LENGTH_BITS;

	avcp_pkg::phase_t phase_q, ph, ph_n;
	avcp_pkg::list_t  list_q, lst, lst_n, lend;
	logic [LW-1:0]    bl_q, bl, bl_n;
	logic [7:0]       prof_q, prof, prof_n;
	logic [7:0]       sl_q, sl, sl_n;
	logic [7:0]       cs_q, cs, cs_n;
	logic [15:0]      pl_q, pl, pl_n;
	logic [15:0]      po_q, po, po_n;
	logic [7:0]       lh_q, lh, lh_n;
	logic             ext_q, ext, ext_n;
	logic             emit, room, do_finish, do_end;
	logic [31:0]      len_wide, len_over;
	logic [LW-1:0]    len_sat, len_start;
	logic [15:0]      full_len;
	logic             take;

	function automatic logic [4:0] len_kind(avcp_pkg::list_t l);
		case (l)
			avcp_pkg::LIST_SPS: return avcp_pkg::KIND_SPSLEN;
			avcp_pkg::LIST_PPS: return avcp_pkg::KIND_PPSLEN;
			default:            return avcp_pkg::KIND_EXTLEN;
		endcase
	endfunction

	function automatic logic [4:0] byte_kind(avcp_pkg::list_t l);
		case (l)
			avcp_pkg::LIST_SPS: return avcp_pkg::KIND_SPSBYTE;
			avcp_pkg::LIST_PPS: return avcp_pkg::KIND_PPSBYTE;
			default:            return avcp_pkg::KIND_EXTBYTE;
		endcase
	endfunction

	function automatic avcp_pkg::phase_t end_phase(avcp_pkg::list_t l, logic r);
		case (l)
			avcp_pkg::LIST_SPS: return avcp_pkg::PH_PPSCOUNT;
			avcp_pkg::LIST_PPS: return r ? avcp_pkg::PH_CHROMA : avcp_pkg::PH_TRAILING;
			default:            return avcp_pkg::PH_TRAILING;
		endcase
	endfunction

	assign in_ready = !q_full;
	assign take     = in_valid && in_ready;
	assign push     = take && emit;

	// Saturate the record length to the counter width; zero counts as one.
	always_comb begin
		len_wide  = {16'd0, record_length};
		len_over  = len_wide >> LW;
		len_sat   = (len_over != 32'd0) ? {LW{1'b1}} : len_wide[LW-1:0];
		len_start = (len_sat == '0) ? LW'(1) : len_sat;
	end

	always_comb begin
		ph   = phase_q;
		lst  = list_q;
		bl   = bl_q;
		prof = prof_q;
		sl   = sl_q;
		cs   = cs_q;
		pl   = pl_q;
		po   = po_q;
		lh   = lh_q;
		ext  = ext_q;
		if (first_byte) begin
			ph   = avcp_pkg::PH_VERSION;
			lst  = avcp_pkg::LIST_SPS;
			bl   = len_start;
			prof = '0;
			sl   = '0;
			cs   = '0;
			pl   = '0;
			po   = '0;
			lh   = '0;
			ext  = 1'b0;
		end
		ph_n      = ph;
		lst_n     = lst;
		bl_n      = bl;
		prof_n    = prof;
		sl_n      = sl;
		cs_n      = cs;
		pl_n      = pl;
		po_n      = po;
		lh_n      = lh;
		ext_n     = ext;
		emit      = 1'b0;
		res       = '0;
		do_finish = 1'b0;
		do_end    = 1'b0;
		lend      = lst;
		room      = 1'b0;
		full_len  = {lh, data_byte};
		if (ph == avcp_pkg::PH_IDLE || bl == '0) begin
			ph_n = avcp_pkg::PH_IDLE;
		end else begin
			emit = 1'b1;
			bl_n = bl - LW'(1);
			room = (bl_n >= LW'(avcp_pkg::EXT_MIN_BYTES)) && avcp_pkg::is_high_profile(prof);
			res.field_value = {8'd0, data_byte};
			case (ph)
				avcp_pkg::PH_VERSION: begin
					res.field_kind = avcp_pkg::KIND_VERSION;
					ph_n = avcp_pkg::PH_PROFILE;
				end
				avcp_pkg::PH_PROFILE: begin
					res.field_kind = avcp_pkg::KIND_PROFILE;
					prof_n = data_byte;
					ph_n = avcp_pkg::PH_COMPAT;
				end
				avcp_pkg::PH_COMPAT: begin
					res.field_kind = avcp_pkg::KIND_COMPAT;
					ph_n = avcp_pkg::PH_LEVEL;
				end
				avcp_pkg::PH_LEVEL: begin
					res.field_kind = avcp_pkg::KIND_LEVEL;
					ph_n = avcp_pkg::PH_LENSIZE;
				end
				avcp_pkg::PH_LENSIZE: begin
					res.field_kind = avcp_pkg::KIND_LENSIZE;
					res.field_value = {8'd0, data_byte & avcp_pkg::MASK_LENSIZE};
					ph_n = avcp_pkg::PH_SPSCOUNT;
				end
				avcp_pkg::PH_SPSCOUNT: begin
					res.field_kind = avcp_pkg::KIND_SPSCOUNT;
					res.field_value = {8'd0, data_byte & avcp_pkg::MASK_SPSCOUNT};
					lst_n = avcp_pkg::LIST_SPS;
					sl_n  = data_byte & avcp_pkg::MASK_SPSCOUNT;
					cs_n  = '0;
					lend  = avcp_pkg::LIST_SPS;
					if (sl_n == '0) do_end = 1'b1;
					else ph_n = avcp_pkg::PH_LEN_HI;
				end
				avcp_pkg::PH_LEN_HI: begin
					res.field_kind  = len_kind(lst);
					res.field_value = {data_byte, 8'd0};
					res.set_index   = cs;
					lh_n = data_byte;
					ph_n = avcp_pkg::PH_LEN_LO;
				end
				avcp_pkg::PH_LEN_LO: begin
					res.field_kind  = len_kind(lst);
					res.field_value = full_len;
					res.set_index   = cs;
					pl_n = full_len;
					po_n = '0;
					if (full_len == '0) do_finish = 1'b1;
					else ph_n = avcp_pkg::PH_PAYLOAD;
				end
				avcp_pkg::PH_PAYLOAD: begin
					res.field_kind = byte_kind(lst);
					res.set_index  = cs;
					res.byte_index = po;
					po_n = po + 16'd1;
					pl_n = pl - 16'd1;
					if (pl_n == '0) do_finish = 1'b1;
				end
				avcp_pkg::PH_PPSCOUNT: begin
					res.field_kind = avcp_pkg::KIND_PPSCOUNT;
					lst_n = avcp_pkg::LIST_PPS;
					sl_n  = data_byte;
					cs_n  = '0;
					lend  = avcp_pkg::LIST_PPS;
					if (data_byte == '0) do_end = 1'b1;
					else ph_n = avcp_pkg::PH_LEN_HI;
				end
				avcp_pkg::PH_CHROMA: begin
					res.field_kind = avcp_pkg::KIND_CHROMA;
					res.field_value = {8'd0, data_byte & avcp_pkg::MASK_CHROMA};
					ph_n = avcp_pkg::PH_LUMA;
				end
				avcp_pkg::PH_LUMA: begin
					res.field_kind = avcp_pkg::KIND_LUMADEPTH;
					res.field_value = {8'd0, data_byte & avcp_pkg::MASK_DEPTH};
					ph_n = avcp_pkg::PH_CHROMAD;
				end
				avcp_pkg::PH_CHROMAD: begin
					res.field_kind = avcp_pkg::KIND_CHROMADEPTH;
					res.field_value = {8'd0, data_byte & avcp_pkg::MASK_DEPTH};
					ph_n = avcp_pkg::PH_EXTCOUNT;
				end
				avcp_pkg::PH_EXTCOUNT: begin
					res.field_kind = avcp_pkg::KIND_EXTCOUNT;
					lst_n = avcp_pkg::LIST_EXT;
					sl_n  = data_byte;
					cs_n  = '0;
					lend  = avcp_pkg::LIST_EXT;
					if (data_byte == '0) do_end = 1'b1;
					else ph_n = avcp_pkg::PH_LEN_HI;
				end
				default: begin
					res.field_kind = avcp_pkg::KIND_TRAILING;
					ph_n = avcp_pkg::PH_TRAILING;
				end
			endcase
			// Close the set; the last set of a list closes the list.
			if (do_finish) begin
				sl_n = sl - 8'd1;
				cs_n = cs + 8'd1;
				lend = lst;
				if (sl_n == '0) do_end = 1'b1;
				else ph_n = avcp_pkg::PH_LEN_HI;
			end
			if (do_end) begin
				ph_n = end_phase(lend, room);
				if (lend == avcp_pkg::LIST_PPS && room) ext_n = 1'b1;
			end
			if (bl_n == '0) begin
				res.record_last = 1'b1;
				res.ext_present = ext_n;
				res.truncated   = (ph_n != avcp_pkg::PH_TRAILING);
				ph_n = avcp_pkg::PH_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= avcp_pkg::PH_IDLE;
			list_q  <= avcp_pkg::LIST_SPS;
			bl_q    <= '0;
			prof_q  <= '0;
			sl_q    <= '0;
			cs_q    <= '0;
			pl_q    <= '0;
			po_q    <= '0;
			lh_q    <= '0;
			ext_q   <= 1'b0;
		end else if (take) begin
			phase_q <= ph_n;
			list_q  <= lst_n;
			bl_q    <= bl_n;
			prof_q  <= prof_n;
			sl_q    <= sl_n;
			cs_q    <= cs_n;
			pl_q    <= pl_n;
			po_q    <= po_n;
			lh_q    <= lh_n;
			ext_q   <= ext_n;
		end
	end

	`AVCP_NEVER(a_idle_silent, push && !first_byte && phase_q == avcp_pkg::PH_IDLE, "word tagged while idle")
	`AVCP_ASSERT(a_ext_needs_hp, ext_q |-> avcp_pkg::is_high_profile(prof_q), "extension without high profile")
	`AVCP_NEVER(a_flags_only_last, push && !res.record_last && (res.truncated || res.ext_present), "end flags off the last word")

endmodule

// File: design/avcp_queue.sv
// Short FIFO between the classifier and the output stage.
`timescale 1ns / 1ps
`include "avc_config_record_parser_top_assert.svh"
module avcp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  avcp_pkg::res_t wdata,
	input  logic           pop,
	output avcp_pkg::res_t rdata,
	output logic           full,
	output logic           empty
);

	avcp_pkg::res_t                    mem_q [avcp_pkg::QUEUE_DEPTH];
	logic [avcp_pkg::QUEUE_PTR_W-1:0] wr_q, rd_q;
	logic [avcp_pkg::QUEUE_PTR_W:0]   cnt_q;

	assign full  = (cnt_q == (avcp_pkg::QUEUE_PTR_W + 1)'(avcp_pkg::QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`AVCP_NEVER(a_no_overflow, push && full, "push into full queue")
	`AVCP_NEVER(a_no_underflow, pop && empty, "pop from empty queue")

endmodule

// File: design/avcp_back.sv
// Output stage: registers one result word toward the downstream side.
`timescale 1ns / 1ps
module avcp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  avcp_pkg::res_t q_data,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output avcp_pkg::res_t out_data
);

	logic           valid_q;
	avcp_pkg::res_t data_q;

	// Refill whenever the register is empty or being drained.
	assign pop       = !q_empty && (!valid_q || out_ready);
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || out_ready) begin
			valid_q <= !q_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= q_data;
		end
	end

endmodule

// File: verif/tb_avc_config_record_parser_top.sv
// Testbench of the configuration record parser: directed table, random records, predictor.
`timescale 1ns / 1ps
module tb_avc_config_record_parser_top;
	import avcp_pkg::*;

	localparam int ITEM_TARGET  = 1750;
	localparam int STALL_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int MAX_REPORTS  = 32;

	typedef struct packed {
		logic [7:0]  data;
		logic        first;
		logic [15:0] len;
		bit          typed;
		bit          typed_has;
		res_t        typed_word;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;   // data_byte[7:0], record_length[23:8]
	logic        s_axis_tuser;   // first_byte
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	// field_value[15:0], set_index[23:16], byte_index[39:24],
	// ext_present[40], truncated[41], zero[47:42]
	logic [47:0] m_axis_tdata;
	logic [4:0]  m_axis_tuser;   // field_kind
	logic        m_axis_tlast;   // record_last

	// Field tracker state, mirrors the parser.
	phase_t      cur_phase;
	list_t       cur_list;
	logic [15:0] rec_left;
	logic [7:0]  seen_profile;
	logic [7:0]  sets_to_go;
	logic [7:0]  set_no;
	logic [15:0] payload_to_go;
	logic [15:0] payload_pos;
	logic [7:0]  len_msb;
	logic        ext_entered;

	res_t        pending_tags[$];
	logic [7:0]  rec_bytes[$];
	stim_row_t   dir_rows[$];

	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_cnt = 0;
	int quiet_cycles = 0;
	int errors = 0;
	int reports = 0;
	int tagged_count = 0;
	bit in_fire = 1'b0;
	bit out_fire = 1'b0;

	avc_config_record_parser_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	always #10 clk = ~clk;

	function automatic logic [7:0] rand_byte();
		logic [31:0] r;
		r = $urandom;
		return r[7:0];
	endfunction

	function automatic logic [15:0] rand16();
		logic [31:0] r;
		r = $urandom;
		return r[15:0];
	endfunction

	function automatic void queue_tag(res_t w);
		pending_tags = {pending_tags, w};
	endfunction

	function automatic void rec_append(logic [7:0] b);
		rec_bytes = {rec_bytes, b};
	endfunction

	function automatic logic ext_profile(logic [7:0] p);
		case (p)
			PROFILE_HIGH, PROFILE_HIGH10, PROFILE_HIGH422, PROFILE_HIGH444: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic [4:0] list_len_kind(list_t which);
		case (which)
			LIST_SPS: return KIND_SPSLEN;
			LIST_PPS: return KIND_PPSLEN;
			default: return KIND_EXTLEN;
		endcase
	endfunction

	function automatic void reset_tracker();
		cur_phase     = PH_IDLE;
		cur_list      = LIST_SPS;
		rec_left      = '0;
		seen_profile  = '0;
		sets_to_go    = '0;
		set_no        = '0;
		payload_to_go = '0;
		payload_pos   = '0;
		len_msb       = '0;
		ext_entered   = 1'b0;
	endfunction

	function automatic void close_list();
		case (cur_list)
			LIST_SPS: cur_phase = PH_PPSCOUNT;
			LIST_PPS: begin
				// extension only for high profiles with room left for its header
				if (rec_left >= EXT_MIN_BYTES && ext_profile(seen_profile)) begin
					ext_entered = 1'b1;
					cur_phase   = PH_CHROMA;
				end else begin
					cur_phase = PH_TRAILING;
				end
			end
			default: cur_phase = PH_TRAILING;
		endcase
	endfunction

	function automatic void open_list(list_t which, logic [7:0] count);
		cur_list   = which;
		sets_to_go = count;
		set_no     = '0;
		if (count == 0)
			close_list();
		else
			cur_phase = PH_LEN_HI;
	endfunction

	function automatic void close_set();
		sets_to_go = sets_to_go - 8'd1;
		set_no     = set_no + 8'd1;
		if (sets_to_go == 0)
			close_list();
		else
			cur_phase = PH_LEN_HI;
	endfunction

	// Tag one accepted byte; returns 1 when the byte yields an output word.
	function automatic bit tag_byte(input logic [7:0] b, input logic first,
			input logic [15:0] len, output res_t w);
		w = '0;
		if (first) begin
			reset_tracker();
			rec_left  = (len == 0) ? 16'd1 : len;
			cur_phase = PH_VERSION;
		end
		if (cur_phase == PH_IDLE || rec_left == 0) begin
			cur_phase = PH_IDLE;
			return 1'b0;
		end
		rec_left = rec_left - 16'd1;
		w.field_value = {8'h00, b};
		case (cur_phase)
			PH_VERSION: begin
				w.field_kind = KIND_VERSION;
				cur_phase = PH_PROFILE;
			end
			PH_PROFILE: begin
				w.field_kind = KIND_PROFILE;
				seen_profile = b;
				cur_phase = PH_COMPAT;
			end
			PH_COMPAT: begin
				w.field_kind = KIND_COMPAT;
				cur_phase = PH_LEVEL;
			end
			PH_LEVEL: begin
				w.field_kind = KIND_LEVEL;
				cur_phase = PH_LENSIZE;
			end
			PH_LENSIZE: begin
				w.field_kind = KIND_LENSIZE;
				w.field_value = {8'h00, b & MASK_LENSIZE};
				cur_phase = PH_SPSCOUNT;
			end
			PH_SPSCOUNT: begin
				w.field_kind = KIND_SPSCOUNT;
				w.field_value = {8'h00, b & MASK_SPSCOUNT};
				open_list(LIST_SPS, b & MASK_SPSCOUNT);
			end
			PH_LEN_HI: begin
				w.field_kind = list_len_kind(cur_list);
				w.field_value = {b, 8'h00};
				w.set_index = set_no;
				len_msb = b;
				cur_phase = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				w.field_kind = list_len_kind(cur_list);
				w.field_value = {len_msb, b};
				w.set_index = set_no;
				payload_to_go = {len_msb, b};
				payload_pos = '0;
				if (payload_to_go == 0)
					close_set();
				else
					cur_phase = PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				case (cur_list)
					LIST_SPS: w.field_kind = KIND_SPSBYTE;
					LIST_PPS: w.field_kind = KIND_PPSBYTE;
					default: w.field_kind = KIND_EXTBYTE;
				endcase
				w.set_index = set_no;
				w.byte_index = payload_pos;
				payload_pos = payload_pos + 16'd1;
				payload_to_go = payload_to_go - 16'd1;
				if (payload_to_go == 0)
					close_set();
			end
			PH_PPSCOUNT: begin
				w.field_kind = KIND_PPSCOUNT;
				open_list(LIST_PPS, b);
			end
			PH_CHROMA: begin
				w.field_kind = KIND_CHROMA;
				w.field_value = {8'h00, b & MASK_CHROMA};
				cur_phase = PH_LUMA;
			end
			PH_LUMA: begin
				w.field_kind = KIND_LUMADEPTH;
				w.field_value = {8'h00, b & MASK_DEPTH};
				cur_phase = PH_CHROMAD;
			end
			PH_CHROMAD: begin
				w.field_kind = KIND_CHROMADEPTH;
				w.field_value = {8'h00, b & MASK_DEPTH};
				cur_phase = PH_EXTCOUNT;
			end
			PH_EXTCOUNT: begin
				w.field_kind = KIND_EXTCOUNT;
				open_list(LIST_EXT, b);
			end
			default: begin
				w.field_kind = KIND_TRAILING;
				cur_phase = PH_TRAILING;
			end
		endcase
		if (rec_left == 0) begin
			w.record_last = 1'b1;
			w.ext_present = ext_entered;
			w.truncated   = (cur_phase != PH_TRAILING);
			cur_phase     = PH_IDLE;
		end
		return 1'b1;
	endfunction

	function automatic res_t last_word(logic [4:0] kind, logic [15:0] value,
			logic ext, logic trunc);
		res_t w;
		w = '0;
		w.field_kind  = kind;
		w.field_value = value;
		w.record_last = 1'b1;
		w.ext_present = ext;
		w.truncated   = trunc;
		return w;
	endfunction

	function automatic string word_text(res_t w);
		return $sformatf("kind %0d value %h set %0d byte %0d last %b ext %b trunc %b",
			w.field_kind, w.field_value, w.set_index, w.byte_index,
			w.record_last, w.ext_present, w.truncated);
	endfunction

	function automatic void add_row(input logic [7:0] d, input logic f, input logic [15:0] l,
			input bit typed = 1'b0, input bit has = 1'b0, input res_t w = '0);
		stim_row_t r;
		r.data       = d;
		r.first      = f;
		r.len        = l;
		r.typed      = typed;
		r.typed_has  = has;
		r.typed_word = w;
		dir_rows = {dir_rows, r};
	endfunction

	// Offer one word, wait for it to be taken, then run the tracker on it.
	task automatic send_word(input logic [7:0] d, input logic f, input logic [15:0] l,
			output bit has, output res_t w);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {l, d};
		s_axis_tuser  <= f;
		do @(posedge clk); while (!in_fire);
		has = tag_byte(d, f, l, w);
	endtask

	task automatic offer_byte(input logic [7:0] d, input logic f, input logic [15:0] l);
		bit has;
		res_t w;
		send_word(d, f, l, has, w);
		if (has) begin
			queue_tag(w);
			tagged_count++;
		end
	endtask

	task automatic add_sets(input int count, input int budget);
		int s, n, k;
		logic [15:0] plen;
		for (s = 0; s < count && rec_bytes.size() <= budget; s++) begin
			plen = rand16();
			if ($urandom_range(0, 99) < 85)
				plen = {13'd0, plen[2:0]};
			rec_append(plen[15:8]);
			rec_append(plen[7:0]);
			// long sets get cut by the budget anyway
			n = (plen > 100) ? 100 : int'(plen);
			for (k = 0; k < n; k++)
				rec_append(rand_byte());
		end
	endtask

	// Build one record in rec_bytes; mostly well formed, sometimes cut or mis-sized.
	task automatic build_record(output logic [15:0] declared, output int nsend);
		int budget, decl, pick;
		logic [7:0] prof, cnt;
		rec_bytes.delete();
		budget = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 12) : $urandom_range(24, 80);
		prof = rand_byte();
		if ($urandom_range(0, 1) == 1) begin
			case ($urandom_range(0, 3))
				0: prof = PROFILE_HIGH;
				1: prof = PROFILE_HIGH10;
				2: prof = PROFILE_HIGH422;
				default: prof = PROFILE_HIGH444;
			endcase
		end
		rec_append(rand_byte());
		rec_append(prof);
		rec_append(rand_byte());
		rec_append(rand_byte());
		rec_append(rand_byte());
		cnt = rand_byte();
		if ($urandom_range(0, 19) != 0)
			cnt[4:0] = {3'b000, cnt[1:0]};
		rec_append(cnt);
		add_sets(int'(cnt[4:0]), budget);
		cnt = rand_byte();
		if ($urandom_range(0, 15) != 0)
			cnt = {6'd0, cnt[1:0]};
		rec_append(cnt);
		add_sets(int'(cnt), budget);
		if (ext_profile(prof) && $urandom_range(0, 4) != 0) begin
			rec_append(rand_byte());
			rec_append(rand_byte());
			rec_append(rand_byte());
			cnt = rand_byte();
			cnt = {6'd0, cnt[1:0]};
			rec_append(cnt);
			add_sets(int'(cnt), budget);
		end
		repeat ($urandom_range(0, 3))
			rec_append(rand_byte());
		while (rec_bytes.size() > budget)
			rec_bytes.delete(rec_bytes.size() - 1);
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			decl  = rec_bytes.size();
			nsend = decl;
		end else if (pick < 85) begin
			decl  = $urandom_range(0, rec_bytes.size() - 1);
			nsend = (decl == 0) ? 1 : decl;
		end else begin
			// declared longer: the next first byte restarts mid-record
			decl  = rec_bytes.size() + $urandom_range(1, 300);
			nsend = rec_bytes.size();
		end
		declared = decl[15:0];
	endtask

	always @(posedge clk) begin
		if (hold_cnt != 0) begin
			hold_cnt = hold_cnt - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Sample both handshakes on the falling edge ahead of the rising edge that completes them.
	always @(negedge clk) begin : check_words
		res_t seen, want;
		in_fire  = s_axis_tvalid && s_axis_tready;
		out_fire = m_axis_tvalid && m_axis_tready;
		if (arst_n && out_fire) begin
			seen = {m_axis_tdata[41], m_axis_tdata[40], m_axis_tlast, m_axis_tdata[39:24],
				m_axis_tdata[23:16], m_axis_tdata[15:0], m_axis_tuser};
			if (pending_tags.size() == 0) begin
				errors++;
				if (reports < MAX_REPORTS)
					$display("%0t: unexpected word: %s", $time, word_text(seen));
				reports++;
			end else begin
				want = pending_tags.pop_front();
				if (seen !== want || m_axis_tdata[47:42] !== 6'd0) begin
					errors++;
					if (reports < MAX_REPORTS)
						$display("%0t: mismatch: expected %s pad 0, actual %s pad %h",
							$time, word_text(want), word_text(seen), m_axis_tdata[47:42]);
					reports++;
				end
			end
		end
		if (in_fire || out_fire)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int ph, i, nsend;
		bit has;
		res_t w;
		logic [15:0] declared;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		m_axis_tready = 1'b0;
		reset_tracker();

		// idle byte after reset, zero length, idle after end
		add_row(8'hA5, 1'b0, 16'hFFFF, 1'b1, 1'b0);
		add_row(8'hFF, 1'b1, 16'h0000, 1'b1, 1'b1, last_word(KIND_VERSION, 16'h00FF, 1'b0, 1'b1));
		add_row(8'h00, 1'b0, 16'h0000, 1'b1, 1'b0);
		// high profile record with one SPS, empty PPS list, extension and a trailing byte
		add_row(8'h01, 1'b1, 16'd17);
		add_row(8'h64, 1'b0, 16'h0000);
		add_row(8'h00, 1'b0, 16'hFFFF);
		add_row(8'hFF, 1'b0, 16'h0000);
		add_row(8'hFF, 1'b0, 16'hFFFF);
		add_row(8'hE1, 1'b0, 16'h0000);
		add_row(8'h00, 1'b0, 16'hFFFF);
		add_row(8'h01, 1'b0, 16'h0000);
		add_row(8'hAB, 1'b0, 16'hFFFF);
		add_row(8'h00, 1'b0, 16'h0000);
		add_row(8'hFF, 1'b0, 16'hFFFF);
		add_row(8'hFF, 1'b0, 16'h0000);
		add_row(8'hFF, 1'b0, 16'hFFFF);
		add_row(8'h01, 1'b0, 16'h0000);
		add_row(8'h00, 1'b0, 16'hFFFF);
		add_row(8'h00, 1'b0, 16'h0000);
		add_row(8'h5A, 1'b0, 16'hFFFF, 1'b1, 1'b1, last_word(KIND_TRAILING, 16'h005A, 1'b1, 1'b0));
		// longest record abandoned by a restart, then cut inside the header
		add_row(8'h00, 1'b1, 16'hFFFF);
		add_row(8'h7E, 1'b0, 16'h0000);
		add_row(8'hC3, 1'b1, 16'd2);
		add_row(8'h64, 1'b0, 16'hFFFF, 1'b1, 1'b1, last_word(KIND_PROFILE, 16'h0064, 1'b0, 1'b1));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < dir_rows.size(); i++) begin
			send_word(dir_rows[i].data, dir_rows[i].first, dir_rows[i].len, has, w);
			if (dir_rows[i].typed) begin
				if (dir_rows[i].typed_has)
					queue_tag(dir_rows[i].typed_word);
			end else if (has) begin
				queue_tag(w);
			end
			if (has)
				tagged_count++;
		end

		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
					// long receiver hold-off while the sender keeps offering
					s_axis_tvalid <= 1'b0;
					@(negedge clk);
					hold_cnt = HOLD_CYCLES;
					@(posedge clk);
				end
				1: begin
					send_idle_pct = 53;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 53;
				end
				default: begin
					send_idle_pct = 37;
					stall_pct = 37;
				end
			endcase
			while (tagged_count < (ph + 1) * ITEM_TARGET / 4) begin
				if ($urandom_range(0, 19) == 0) begin
					// junk record: random length, a few random bytes
					offer_byte(rand_byte(), 1'b1, rand16());
					repeat ($urandom_range(0, 12))
						offer_byte(rand_byte(), 1'b0, rand16());
				end else begin
					build_record(declared, nsend);
					for (i = 0; i < nsend; i++)
						offer_byte(rec_bytes[i], i == 0, (i == 0) ? declared : rand16());
				end
				if ($urandom_range(0, 3) == 0) begin
					repeat ($urandom_range(1, 3))
						offer_byte(rand_byte(), 1'b0, rand16());
				end
			end
		end
		s_axis_tvalid <= 1'b0;

		while (pending_tags.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_tags.size() != 0) begin
			errors += pending_tags.size();
			$display("%0t: %0d expected words never arrived", $time, pending_tags.size());
		end
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
